[src/lpg_pkg.sv]
// -----------------------------------------------------------------------------
// lpg_pkg
// Shared widths, register indexes and the line command type.
// -----------------------------------------------------------------------------
package lpg_pkg;

  localparam int CoordW = 6;
  localparam int ErrW   = CoordW + 2;
  localparam int AddrW  = 32;
  localparam int ColorW = 32;
  localparam int PitchW = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegFrameBase = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLinePitch = 1'b1;

  localparam logic [AddrW-1:0]  FrameBaseRst = 32'd0;
  localparam logic [PitchW-1:0] LinePitchRst = 16'd256;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t                  start_x;
    coord_t                  start_y;
    coord_t                  end_x;
    coord_t                  end_y;
    coord_t                  span_x;
    coord_t                  span_y;
    logic                    step_x_neg;
    logic                    step_y_neg;
    logic signed [ErrW-1:0]  err_init;
    logic [ColorW-1:0]       color;
  } line_cmd_t;

  typedef struct packed {
    logic      valid;
    line_cmd_t cmd;
  } cmd_push_t;

endpackage

[src/lpg_cmd_if.sv]
// -----------------------------------------------------------------------------
// lpg_cmd_if
// Line command channel: two endpoints and a color.
// -----------------------------------------------------------------------------
interface lpg_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [lpg_pkg::CoordW-1:0]  start_x;
  logic [lpg_pkg::CoordW-1:0]  start_y;
  logic [lpg_pkg::CoordW-1:0]  end_x;
  logic [lpg_pkg::CoordW-1:0]  end_y;
  logic [lpg_pkg::ColorW-1:0]  color;

  modport source (output valid, start_x, start_y, end_x, end_y, color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, color, output ready);
endinterface

[src/lpg_pix_if.sv]
// -----------------------------------------------------------------------------
// lpg_pix_if
// Pixel channel: coordinates, byte address, color and last flag.
// -----------------------------------------------------------------------------
interface lpg_pix_if;
  logic                        valid;
  logic                        ready;
  logic [lpg_pkg::CoordW-1:0]  pixel_x;
  logic [lpg_pkg::CoordW-1:0]  pixel_y;
  logic [lpg_pkg::AddrW-1:0]   pixel_address;
  logic [lpg_pkg::ColorW-1:0]  pixel_color;
  logic                        last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
                  output ready);
endinterface

[src/line_pixel_generator_top.sv]
// -----------------------------------------------------------------------------
// line_pixel_generator_top
// Bresenham line rasterizer with frame-buffer address generation.
// -----------------------------------------------------------------------------
// cmd_i takes one line command (two endpoints, color); pix_o returns one item
// per pixel, start to end, with last_pixel set on the final one. A line gives
// max(|dx|,|dy|)+1 items, at most 64.
// A command passes through the queue and is loaded into the stepper, whose
// pixels are registered into pix_o: one pixel per cycle while pix_o is ready.
// Each command takes a load step in the stepper before its first pixel.
// A two-entry command queue lets cmd_i keep accepting while a line is drawn.
// When pix_o stalls the stepper holds; once the queue fills, cmd_i drops ready.
// Address = frame_base + y*line_pitch + x*4, modulo 2^32 (one 6x16 multiply).
// cfg_we_i writes frame_base (index 0) or line_pitch (index 1); write only
// while idle. Reset clears the queue and output; frame_base resets to 0 and
// line_pitch to 256.
// -----------------------------------------------------------------------------
module line_pixel_generator_top #(
  parameter int COORD_BITS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lpg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lpg_pkg::CfgDataW-1:0]    cfg_data_i,
  lpg_cmd_if.sink                         cmd_i,
  lpg_pix_if.source                       pix_o
);

  logic [lpg_pkg::AddrW-1:0]  frame_base_q;
  logic [lpg_pkg::PitchW-1:0] line_pitch_q;
  lpg_pkg::cmd_push_t         push;
  lpg_pkg::line_cmd_t         head;
  logic                       full, empty, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= lpg_pkg::FrameBaseRst;
      line_pitch_q <= lpg_pkg::LinePitchRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpg_pkg::RegFrameBase: frame_base_q <= cfg_data_i;
        lpg_pkg::RegLinePitch: line_pitch_q <= cfg_data_i[lpg_pkg::PitchW-1:0];
        default: ;
      endcase
    end
  end

  lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push)
  );

  lpg_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head)
  );

  lpg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .cmd_i        (head),
    .pop_o        (pop),
    .frame_base_i (frame_base_q),
    .line_pitch_i (line_pitch_q),
    .pix_o        (pix_o)
  );

endmodule

[src/lpg_front.sv]
// -----------------------------------------------------------------------------
// lpg_front
// Accept line commands, derive spans, directions and the initial error.
// -----------------------------------------------------------------------------
module lpg_front #(
  parameter int COORD_BITS = 6
) (
  lpg_cmd_if.sink              cmd_i,
  input  logic                 full_i,
  output lpg_pkg::cmd_push_t   push_o
);

  localparam logic [lpg_pkg::CoordW-1:0] CoordMask =
    lpg_pkg::CoordW'((1 << COORD_BITS) - 1);

  lpg_pkg::coord_t sx, sy, ex, ey, dx, dy;

  always_comb begin
    sx = cmd_i.start_x & CoordMask;
    sy = cmd_i.start_y & CoordMask;
    ex = cmd_i.end_x & CoordMask;
    ey = cmd_i.end_y & CoordMask;
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;

    push_o.valid          = cmd_i.valid && !full_i;
    push_o.cmd.start_x    = sx;
    push_o.cmd.start_y    = sy;
    push_o.cmd.end_x      = ex;
    push_o.cmd.end_y      = ey;
    push_o.cmd.span_x     = dx;
    push_o.cmd.span_y     = dy;
    push_o.cmd.step_x_neg = !(sx < ex);
    push_o.cmd.step_y_neg = !(sy < ey);
    push_o.cmd.err_init   = (dx > dy) ?  $signed({3'b000, dx[lpg_pkg::CoordW-1:1]})
                                      : -$signed({3'b000, dy[lpg_pkg::CoordW-1:1]});
    push_o.cmd.color      = cmd_i.color;
  end

  assign cmd_i.ready = !full_i;

endmodule

[src/lpg_cmd_fifo.sv]
// -----------------------------------------------------------------------------
// lpg_cmd_fifo
// Two-entry queue of decoded line commands between front and back.
// -----------------------------------------------------------------------------
module lpg_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpg_pkg::cmd_push_t  push_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output lpg_pkg::line_cmd_t  cmd_o
);

  lpg_pkg::line_cmd_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i.valid;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(push_i.valid) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

[src/lpg_back.sv]
// -----------------------------------------------------------------------------
// lpg_back
// Step one line command pixel by pixel into a registered pixel output.
// -----------------------------------------------------------------------------
module lpg_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  lpg_pkg::line_cmd_t           cmd_i,
  output logic                         pop_o,
  input  logic [lpg_pkg::AddrW-1:0]    frame_base_i,
  input  logic [lpg_pkg::PitchW-1:0]   line_pitch_i,
  lpg_pix_if.source                    pix_o
);

  localparam int ProdW = lpg_pkg::CoordW + lpg_pkg::PitchW;

  logic                            busy_q, busy_d;
  lpg_pkg::coord_t                 x_q, x_d, y_q, y_d;
  lpg_pkg::coord_t                 ex_q, ey_q, dx_q, dy_q;
  logic                            sxn_q, syn_q;
  logic signed [lpg_pkg::ErrW-1:0] err_q, err_d;
  logic [lpg_pkg::ColorW-1:0]      color_q;

  logic                            ovalid_q, ovalid_d;
  lpg_pkg::coord_t                 ox_q, oy_q;
  logic [lpg_pkg::AddrW-1:0]       oaddr_q;
  logic [lpg_pkg::ColorW-1:0]      ocolor_q;
  logic                            olast_q;

  logic                            adv, last, x_step, y_step;
  logic signed [lpg_pkg::ErrW-1:0] sdx, sdy;
  logic [ProdW-1:0]                row_off;
  logic [lpg_pkg::AddrW-1:0]       addr;

  always_comb begin
    sdx     = $signed({2'b00, dx_q});
    sdy     = $signed({2'b00, dy_q});
    last    = (x_q == ex_q) && (y_q == ey_q);
    adv     = busy_q && (!ovalid_q || pix_o.ready);
    pop_o   = !busy_q && !empty_i;
    x_step  = err_q > -sdx;
    y_step  = err_q < sdy;
    row_off = ProdW'(y_q) * ProdW'(line_pitch_i);
    addr    = frame_base_i + lpg_pkg::AddrW'(row_off)
            + lpg_pkg::AddrW'({x_q, 2'b00});

    busy_d   = busy_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    ovalid_d = ovalid_q && !pix_o.ready;
    if (pop_o) begin
      busy_d = 1'b1;
      x_d    = cmd_i.start_x;
      y_d    = cmd_i.start_y;
      err_d  = cmd_i.err_init;
    end else if (adv) begin
      ovalid_d = 1'b1;
      busy_d   = !last;
      err_d    = err_q - (x_step ? sdy : '0) + (y_step ? sdx : '0);
      if (x_step) begin
        x_d = sxn_q ? x_q - 1'b1 : x_q + 1'b1;
      end
      if (y_step) begin
        y_d = syn_q ? y_q - 1'b1 : y_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    err_q <= err_d;
    if (pop_o) begin
      ex_q    <= cmd_i.end_x;
      ey_q    <= cmd_i.end_y;
      dx_q    <= cmd_i.span_x;
      dy_q    <= cmd_i.span_y;
      sxn_q   <= cmd_i.step_x_neg;
      syn_q   <= cmd_i.step_y_neg;
      color_q <= cmd_i.color;
    end
    if (adv) begin
      ox_q     <= x_q;
      oy_q     <= y_q;
      oaddr_q  <= addr;
      ocolor_q <= color_q;
      olast_q  <= last;
    end
  end

  assign pix_o.valid         = ovalid_q;
  assign pix_o.pixel_x       = ox_q;
  assign pix_o.pixel_y       = oy_q;
  assign pix_o.pixel_address = oaddr_q;
  assign pix_o.pixel_color   = ocolor_q;
  assign pix_o.last_pixel    = olast_q;

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy_q)
    else $error("command popped while a line is in progress");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last) |=> (!busy_q && pix_o.valid && pix_o.last_pixel))
    else $error("line did not end on its last pixel");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !adv) |=> ($stable(x_q) && $stable(y_q) && $stable(err_q)))
    else $error("stepper advanced while stalled");

endmodule
